[rtl/socr_pkg.sv]
`default_nettype none
package socr_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_TICK   = 2'd2
    } op_kind_t;

    typedef enum logic [1:0] {
        RK_SAMPLE = 2'd0,
        RK_OK     = 2'd1,
        RK_FAIL   = 2'd2
    } res_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_OK
    } back_state_t;

    // classified item as it travels from front to back
    typedef struct packed {
        op_kind_t    kind;
        logic [3:0]  channel;
        logic [15:0] frames;
    } op_ctl_t;

    localparam logic [1:0]  CMD_SAMPLE = 2'd0;
    localparam logic [1:0]  CMD_START  = 2'd1;
    localparam logic [1:0]  CMD_TICK   = 2'd2;

    localparam logic [1:0]  REG_CHANNEL_COUNT  = 2'd0;
    localparam logic [1:0]  REG_DEFAULT_FRAMES = 2'd1;
    localparam logic [1:0]  REG_TIMEOUT_TICKS  = 2'd2;

    localparam logic [4:0]  RESET_CHANNEL_COUNT = 5'd12;
    localparam logic [15:0] RESET_FRAMES        = 16'd100;
    localparam logic [7:0]  RESET_TIMEOUT       = 8'd100;

endpackage
`default_nettype wire

[rtl/socr_if.sv]
`default_nettype none
interface socr_in_if #(parameter int SAMPLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic [3:0]             channel;
    logic [SAMPLE_BITS-1:0] voltage;
    logic [15:0]            requested_frames;

    modport source (output valid, command, channel, voltage, requested_frames, input ready);
    modport sink (input valid, command, channel, voltage, requested_frames, output ready);
endinterface

interface socr_out_if #(parameter int SAMPLE_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [3:0]           out_channel;
    logic [SAMPLE_BITS:0] corrected;
    logic                 last;

    modport source (output valid, kind, out_channel, corrected, last, input ready);
    modport sink (input valid, kind, out_channel, corrected, last, output ready);
endinterface
`default_nettype wire

[rtl/socr_front.sv]
`default_nettype none
module socr_front #(
    parameter int SAMPLE_BITS = 16
) (
    socr_in_if.sink                 in_ch,
    input  logic [6:0]              cnt_eff,
    input  logic                    q_full,
    output logic                    push,
    output socr_pkg::op_ctl_t       op_ctl,
    output logic [SAMPLE_BITS-1:0]  op_voltage
);
    import socr_pkg::*;

    logic keep;

    assign in_ch.ready = !q_full;

    // drop unused codes and out-of-range channels here so the back never sees them
    always_comb
    begin
        unique case (in_ch.command)
            CMD_SAMPLE: keep = ({3'b000, in_ch.channel} < cnt_eff);
            CMD_START:  keep = 1'b1;
            CMD_TICK:   keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign push           = in_ch.valid && !q_full && keep;
    assign op_ctl.kind    = op_kind_t'(in_ch.command);
    assign op_ctl.channel = in_ch.channel;
    assign op_ctl.frames  = in_ch.requested_frames;
    assign op_voltage     = in_ch.voltage;

endmodule
`default_nettype wire

[rtl/socr_queue.sv]
`default_nettype none
module socr_queue #(
    parameter int WIDTH = 38
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/socr_back.sv]
`default_nettype none
module socr_back #(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  socr_pkg::op_ctl_t       op_ctl,
    input  logic [SAMPLE_BITS-1:0]  op_voltage,
    input  logic                    op_avail,
    output logic                    op_pop,
    input  logic [6:0]              cnt_eff,
    input  logic [15:0]             default_frames,
    input  logic [7:0]              timeout_ticks,
    socr_out_if.source              out_ch
);
    import socr_pkg::*;

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW = SAMPLE_BITS + 16;
    localparam int BW = $clog2(SW);

    back_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] bias_reg [MAX_CHANNELS];
    logic [SW-1:0]          sum_reg [MAX_CHANNELS];
    logic [15:0]            frames_seen_reg;
    logic [15:0]            frames_wanted_reg;
    logic                   calibrating_reg;
    logic                   initial_reg;
    logic                   publish_reg;
    logic [7:0]             idle_reg;
    logic [CW-1:0]          div_idx_reg;
    logic [BW-1:0]          bit_cnt_reg;
    logic [SW-1:0]          dvd_reg;
    logic [15:0]            rem_reg;
    logic                   neg_reg;

    logic                   out_valid_reg;
    logic [1:0]             out_kind_reg;
    logic [3:0]             out_chan_reg;
    logic [SAMPLE_BITS:0]   out_corr_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic                   take;
    logic                   is_sample;
    logic                   is_start;
    logic                   is_tick;
    logic [CW-1:0]          op_idx;
    logic [CW-1:0]          rd_idx;
    logic [SW-1:0]          sum_rd;
    logic [SAMPLE_BITS-1:0] bias_rd;
    logic                   frame_end;
    logic [15:0]            seen_inc;
    logic                   cal_done;
    logic [7:0]             tick_inc;
    logic [7:0]             tick_lim;
    logic                   tick_fail;
    logic                   do_start;
    logic [15:0]            def_eff;
    logic [15:0]            start_frames;
    logic [SAMPLE_BITS:0]   corr_val;
    logic [16:0]            rem_sh;
    logic                   rem_ge;
    logic [15:0]            rem_new;
    logic [SW-1:0]          dvd_new;
    logic                   bit_last;
    logic                   chan_last;
    logic [SAMPLE_BITS-1:0] quot;
    logic                   load_out;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign take      = (state_reg == ST_IDLE) && op_avail && out_free;
    assign op_pop    = take;
    assign is_sample = take && (op_ctl.kind == OP_SAMPLE);
    assign is_start  = take && (op_ctl.kind == OP_START);
    assign is_tick   = take && (op_ctl.kind == OP_TICK);

    assign op_idx  = CW'({4'b0000, op_ctl.channel});
    assign rd_idx  = (state_reg == ST_IDLE) ? op_idx : div_idx_reg;
    assign sum_rd  = sum_reg[rd_idx];
    assign bias_rd = bias_reg[rd_idx];

    assign frame_end = ({3'b000, op_ctl.channel} == (cnt_eff - 7'd1));
    assign seen_inc  = frames_seen_reg + 16'd1;
    assign cal_done  = is_sample && calibrating_reg && frame_end
                       && (seen_inc == frames_wanted_reg);

    assign tick_inc  = idle_reg + 8'd1;
    assign tick_lim  = (timeout_ticks == 8'd0) ? 8'd1 : timeout_ticks;
    assign tick_fail = is_tick && calibrating_reg && (tick_inc >= tick_lim);

    assign def_eff      = (default_frames == 16'd0) ? 16'd1 : default_frames;
    assign do_start     = is_start || (tick_fail && initial_reg);
    assign start_frames = (is_start && (op_ctl.frames != 16'd0)) ? op_ctl.frames : def_eff;

    assign corr_val = {op_voltage[SAMPLE_BITS-1], op_voltage}
                      - {bias_rd[SAMPLE_BITS-1], bias_rd};

    // one quotient bit per cycle, restoring
    assign rem_sh   = {rem_reg, dvd_reg[SW-1]};
    assign rem_ge   = (rem_sh >= {1'b0, frames_wanted_reg});
    assign rem_new  = rem_ge ? 16'(rem_sh - {1'b0, frames_wanted_reg}) : rem_sh[15:0];
    assign dvd_new  = {dvd_reg[SW-2:0], rem_ge};
    assign bit_last = (bit_cnt_reg == BW'(SW - 1));
    assign chan_last = (7'(div_idx_reg) == (cnt_eff - 7'd1));
    assign quot     = neg_reg ? (SAMPLE_BITS'(0) - dvd_new[SAMPLE_BITS-1:0])
                              : dvd_new[SAMPLE_BITS-1:0];

    assign load_out = (is_sample && publish_reg) || tick_fail
                      || ((state_reg == ST_OK) && out_free);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cal_done)
                begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (bit_last)
                begin
                    state_next = chan_last ? ST_OK : ST_DIV_LOAD;
                end
            end
            ST_OK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                bias_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
            frames_seen_reg   <= 16'd0;
            frames_wanted_reg <= RESET_FRAMES;
            calibrating_reg   <= 1'b1;
            initial_reg       <= 1'b1;
            publish_reg       <= 1'b0;
            idle_reg          <= 8'd0;
            div_idx_reg       <= '0;
            bit_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (do_start)
            begin
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    sum_reg[i] <= '0;
                end
                frames_seen_reg   <= 16'd0;
                idle_reg          <= 8'd0;
                frames_wanted_reg <= start_frames;
                calibrating_reg   <= 1'b1;
            end
            else if (tick_fail)
            begin
                calibrating_reg <= 1'b0;
                idle_reg        <= 8'd0;
            end
            else if (is_tick && calibrating_reg)
            begin
                idle_reg <= tick_inc;
            end

            if (is_sample && calibrating_reg)
            begin
                sum_reg[rd_idx] <= sum_rd + {{16{op_voltage[SAMPLE_BITS-1]}}, op_voltage};
                if (frame_end)
                begin
                    idle_reg        <= 8'd0;
                    frames_seen_reg <= seen_inc;
                end
            end

            if (cal_done)
            begin
                div_idx_reg <= '0;
            end

            if (state_reg == ST_DIV_LOAD)
            begin
                bit_cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV_RUN)
            begin
                bit_cnt_reg <= bit_cnt_reg + BW'(1);
                if (bit_last)
                begin
                    bias_reg[div_idx_reg] <= quot;
                    if (chan_last)
                    begin
                        calibrating_reg <= 1'b0;
                        initial_reg     <= 1'b0;
                        publish_reg     <= 1'b1;
                    end
                    else
                    begin
                        div_idx_reg <= div_idx_reg + CW'(1);
                    end
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // divider datapath and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV_LOAD)
        begin
            neg_reg <= sum_rd[SW-1];
            dvd_reg <= sum_rd[SW-1] ? (SW'(0) - sum_rd) : sum_rd;
            rem_reg <= 16'd0;
        end
        else if (state_reg == ST_DIV_RUN)
        begin
            dvd_reg <= dvd_new;
            rem_reg <= rem_new;
        end

        if (load_out)
        begin
            if (state_reg == ST_OK)
            begin
                out_kind_reg <= RK_OK;
                out_chan_reg <= 4'd0;
                out_corr_reg <= '0;
                out_last_reg <= 1'b1;
            end
            else if (tick_fail)
            begin
                out_kind_reg <= RK_FAIL;
                out_chan_reg <= 4'd0;
                out_corr_reg <= '0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_kind_reg <= RK_SAMPLE;
                out_chan_reg <= op_ctl.channel;
                out_corr_reg <= corr_val;
                out_last_reg <= !cal_done;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = out_kind_reg;
    assign out_ch.out_channel = out_chan_reg;
    assign out_ch.corrected   = out_corr_reg;
    assign out_ch.last        = out_last_reg;

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !calibrating_reg |-> (idle_reg == 8'd0))
        else $error("idle count nonzero outside calibration");

    a_div_cal: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV_LOAD) || (state_reg == ST_DIV_RUN)) |-> calibrating_reg)
        else $error("bias division without calibration");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        calibrating_reg |-> (frames_seen_reg <= frames_wanted_reg))
        else $error("frame count passed target");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !op_pop)
        else $error("item taken during bias update");

endmodule
`default_nettype wire

[rtl/sensor_offset_calibrate_remove.sv]
// Multichannel sensor offset calibration and removal.
// in_ch  : items with command (sample, start calibration, tick), channel, signed
//          voltage and requested frame count; valid/ready handshake.
// out_ch : results: corrected sample, calibration ok, calibration failed; last
//          marks the final result of an item. valid/ready handshake.
// cfg_*  : write port: index 0 channel_count, 1 default_frames, 2 timeout_ticks.
// An accepted item waits in the queue; its result is held in an output register.
// Throughput: one item per cycle while out_ch keeps up and the divider is
// idle; the two-entry queue lets the input keep flowing for two items while
// the output stalls. At the close of a calibration the bias divider (one
// quotient bit per cycle) takes each channel in turn through a load and a
// run state, during which no item leaves the queue; the ok result follows that.
// Reset: bias zero, publishing off, and an initial calibration over
// default_frames starts at once and restarts after every timeout until it
// succeeds. No clearing pass is needed.
// A stalled receiver holds the output register; the queue then fills and
// in_ch.ready drops.
`default_nettype none
module sensor_offset_calibrate_remove #(
    parameter int MAX_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    socr_in_if.sink     in_ch,
    socr_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import socr_pkg::*;

    localparam int QW = $bits(op_ctl_t) + SAMPLE_BITS;

    logic [4:0]             chan_count_reg;
    logic [15:0]            def_frames_reg;
    logic [7:0]             timeout_reg;
    logic [6:0]             cnt_eff;

    logic                   push;
    op_ctl_t                f_ctl;
    logic [SAMPLE_BITS-1:0] f_volt;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [QW-1:0]          q_data;
    op_ctl_t                b_ctl;
    logic [SAMPLE_BITS-1:0] b_volt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= RESET_CHANNEL_COUNT;
            def_frames_reg <= RESET_FRAMES;
            timeout_reg    <= RESET_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT:  chan_count_reg <= cfg_data[4:0];
                REG_DEFAULT_FRAMES: def_frames_reg <= cfg_data;
                REG_TIMEOUT_TICKS:  timeout_reg    <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // zero acts as one, above the table depth acts as the depth
    always_comb
    begin
        if (chan_count_reg == 5'd0)
        begin
            cnt_eff = 7'd1;
        end
        else if ({2'b00, chan_count_reg} > 7'(MAX_CHANNELS))
        begin
            cnt_eff = 7'(MAX_CHANNELS);
        end
        else
        begin
            cnt_eff = {2'b00, chan_count_reg};
        end
    end

    socr_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .in_ch      (in_ch),
        .cnt_eff    (cnt_eff),
        .q_full     (q_full),
        .push       (push),
        .op_ctl     (f_ctl),
        .op_voltage (f_volt)
    );

    socr_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_ctl, f_volt}),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign b_ctl  = op_ctl_t'(q_data[QW-1:SAMPLE_BITS]);
    assign b_volt = q_data[SAMPLE_BITS-1:0];

    socr_back #(.MAX_CHANNELS(MAX_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .op_ctl         (b_ctl),
        .op_voltage     (b_volt),
        .op_avail       (!q_empty),
        .op_pop         (q_pop),
        .cnt_eff        (cnt_eff),
        .default_frames (def_frames_reg),
        .timeout_ticks  (timeout_reg),
        .out_ch         (out_ch)
    );

endmodule
`default_nettype wire

[tb/tb_sensor_offset_calibrate_remove.sv]
`default_nettype none
// Bias calibration block: items go in through a valid/ready channel, results
// come out through another. Every accepted item runs through a local model
// of the block; results are checked in order against it or hand-typed expectations.
module tb_sensor_offset_calibrate_remove;
    import socr_pkg::*;

    localparam int          NCH         = 16;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;  // no meaning, block drops it
    localparam int          CFG_SETTLE  = 600;   // longer than a full bias division over 16 ch
    localparam int          STALL_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         chan;
        logic signed [16:0] value;
        logic               last;
    } result_t;

    typedef struct {
        logic [1:0]         cmd;
        logic [3:0]         chan;
        logic signed [15:0] volts;
        logic [15:0]        req;
        bit                 typed;   // expectation below is typed in by hand
        int                 n_res;
        result_t            r0;
        result_t            r1;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    socr_in_if  #(.SAMPLE_BITS(16)) in_ch ();
    socr_out_if #(.SAMPLE_BITS(16)) out_ch ();

    sensor_offset_calibrate_remove #(
        .MAX_CHANNELS(NCH),
        .SAMPLE_BITS (16)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Local copy of the block state
    // ---------------------------------------------------------------------
    logic [4:0]    m_count;
    logic [15:0]   m_default;
    logic [7:0]    m_timeout;
    longint        bias[NCH];
    longint        accum[NCH];
    logic [15:0]   frames_done;
    logic [15:0]   frames_goal;
    bit            calibrating;
    bit            first_pass;
    bit            publishing;
    logic [7:0]    quiet_ticks;

    result_t       pending_results[$];
    row_t          rows[$];
    int            errors;
    int            src_idle_pct;
    int            snk_idle_pct;
    int            stall_cycles;

    function automatic int chans_in_frame();
        if (m_count == 0) return 1;
        if (int'(m_count) > NCH) return NCH;
        return int'(m_count);
    endfunction

    function automatic int timeout_limit();
        return (m_timeout == 0) ? 1 : int'(m_timeout);
    endfunction

    function automatic void begin_calibration(logic [15:0] frames);
        for (int i = 0; i < NCH; i++) accum[i] = 0;
        frames_done = 0;
        quiet_ticks = 0;
        frames_goal = (frames == 0) ? 16'd1 : frames;
        calibrating = 1'b1;
    endfunction

    function automatic void model_reset();
        m_count   = RESET_CHANNEL_COUNT;
        m_default = RESET_FRAMES;
        m_timeout = RESET_TIMEOUT;
        for (int i = 0; i < NCH; i++) bias[i] = 0;
        first_pass = 1'b1;
        publishing = 1'b0;
        begin_calibration(m_default);
    endfunction

    function automatic result_t mk_res(logic [1:0] kind, logic [3:0] chan,
                                       longint value, logic last);
        result_t r;
        r.kind  = kind;
        r.chan  = chan;
        r.value = value[16:0];
        r.last  = last;
        return r;
    endfunction

    // Advance the model by one accepted item; results are queued when keep.
    function automatic void correct_and_calibrate(logic [1:0] cmd, logic [3:0] chan,
                                                  logic signed [15:0] volts,
                                                  logic [15:0] req, bit keep);
        result_t out[$];
        int      cnt;
        longint  v;
        cnt = chans_in_frame();
        v   = volts;
        case (cmd)
            CMD_SAMPLE:
                if (int'(chan) < cnt) begin
                    if (publishing)
                        out.push_back(mk_res(RK_SAMPLE, chan, v - bias[chan], 1'b0));
                    if (calibrating) begin
                        accum[chan] += v;
                        if (int'(chan) == cnt - 1) begin
                            quiet_ticks = 0;
                            frames_done = frames_done + 16'd1;
                            if (frames_done == frames_goal) begin
                                for (int i = 0; i < cnt; i++)
                                    bias[i] = accum[i] / longint'(frames_goal);
                                calibrating = 1'b0;
                                first_pass  = 1'b0;
                                publishing  = 1'b1;
                                out.push_back(mk_res(RK_OK, 0, 0, 1'b0));
                            end
                        end
                    end
                end
            CMD_START:
                begin_calibration((req != 0) ? req : m_default);
            CMD_TICK:
                if (calibrating) begin
                    quiet_ticks = quiet_ticks + 8'd1;
                    if (int'(quiet_ticks) >= timeout_limit()) begin
                        out.push_back(mk_res(RK_FAIL, 0, 0, 1'b0));
                        if (first_pass) begin
                            begin_calibration(m_default);
                        end
                        else begin
                            calibrating = 1'b0;
                            quiet_ticks = 0;
                        end
                    end
                end
            default: ;
        endcase
        if (out.size() > 0) out[out.size() - 1].last = 1'b1;
        if (keep)
            foreach (out[i]) pending_results.push_back(out[i]);
    endfunction

    // ---------------------------------------------------------------------
    // Clock and watchdog
    // ---------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Any handshake or register write counts as progress.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random back-pressure, in-order compare
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t exp_r;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else begin
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result kind=%0d ch=%0d corrected=%0d",
                           out_ch.kind, out_ch.out_channel, $signed(out_ch.corrected));
                    errors++;
                end
                else begin
                    exp_r = pending_results.pop_front();
                    if (out_ch.kind !== exp_r.kind) begin
                        $error("kind: expected %0d got %0d", exp_r.kind, out_ch.kind);
                        errors++;
                    end
                    if (out_ch.out_channel !== exp_r.chan) begin
                        $error("out_channel: expected %0d got %0d",
                               exp_r.chan, out_ch.out_channel);
                        errors++;
                    end
                    if (out_ch.corrected !== exp_r.value) begin
                        $error("corrected: expected %0d got %0d",
                               exp_r.value, $signed(out_ch.corrected));
                        errors++;
                    end
                    if (out_ch.last !== exp_r.last) begin
                        $error("last: expected %0d got %0d", exp_r.last, out_ch.last);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    // One item; valid stays high into the next item unless the sender idles.
    task automatic send_item(logic [1:0] cmd, logic [3:0] chan,
                             logic signed [15:0] volts, logic [15:0] req,
                             bit typed, int n_res, result_t r0, result_t r1);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.command          <= cmd;
        in_ch.channel          <= chan;
        in_ch.voltage          <= volts;
        in_ch.requested_frames <= req;
        do @(posedge clk); while (!in_ch.ready);
        correct_and_calibrate(cmd, chan, volts, req, !typed);
        if (typed) begin
            if (n_res > 0) pending_results.push_back(r0);
            if (n_res > 1) pending_results.push_back(r1);
        end
    endtask

    task automatic send(logic [1:0] cmd, logic [3:0] chan,
                        logic signed [15:0] volts, logic [15:0] req);
        send_item(cmd, chan, volts, req, 1'b0, 0, '0, '0);
    endtask

    // Makes the block idle before returning: input quiet and nothing in flight.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    // Back-to-back writes of all three registers; enable drops once.
    task automatic write_regs(logic [4:0] cnt, logic [15:0] dflt, logic [7:0] tmo);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= 16'(cnt);
        @(posedge clk);
        cfg_index <= REG_DEFAULT_FRAMES;
        cfg_data  <= dflt;
        @(posedge clk);
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_data  <= 16'(tmo);
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_count   = cnt;
        m_default = dflt;
        m_timeout = tmo;
    endtask

    function automatic logic signed [15:0] pick_volts();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [3:0] chan,
                                    logic signed [15:0] volts, logic [15:0] req);
        row_t r;
        r = '{cmd, chan, volts, req, 1'b0, 0, '0, '0};
        rows.push_back(r);
    endfunction

    function automatic void add_typed(logic [1:0] cmd, logic [3:0] chan,
                                      logic signed [15:0] volts, logic [15:0] req,
                                      int n_res, result_t r0, result_t r1);
        row_t r;
        r = '{cmd, chan, volts, req, 1'b1, n_res, r0, r1};
        rows.push_back(r);
    endfunction

    // Random part for one register setting: mostly whole frames with random
    // content, plus starts, ticks, timeout bursts, partial frames and a share of noise.
    task automatic random_phase(int n_items);
        int sent;
        int cnt;
        int len;
        int sel;
        sent = 0;
        while (sent < n_items) begin
            cnt = chans_in_frame();
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                for (int c = 0; c < cnt; c++)
                    send(CMD_SAMPLE, 4'(c), pick_volts(), 16'($urandom));
                sent += cnt;
            end
            else if (sel < 65) begin
                send(CMD_START, 4'($urandom), 16'($urandom),
                     ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
                sent++;
            end
            else if (sel < 75) begin
                len = $urandom_range(1, 3);
                repeat (len) send(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
                sent += len;
            end
            else if (sel < 80) begin
                // long silence: enough ticks to time out
                if (timeout_limit() <= 50 || $urandom_range(0, 9) == 0) begin
                    len = timeout_limit();
                    repeat (len) send(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
                    sent += len;
                end
            end
            else if (sel < 90) begin
                // partial frame, then a start lands mid-frame
                len = $urandom_range(0, cnt - 1);
                for (int c = 0; c < len; c++)
                    send(CMD_SAMPLE, 4'(c), pick_volts(), 16'($urandom));
                send(CMD_START, 4'($urandom), 16'($urandom), 16'($urandom_range(1, 3)));
                sent += len + 1;
            end
            else begin
                send(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        row_t r;
        logic [4:0]  cnt_set[6];
        logic [15:0] dflt_set[6];
        logic [7:0]  tmo_set[6];

        cnt_set                = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd4, 5'd12};
        dflt_set               = '{16'd0, 16'd65535, 16'd3, 16'd2, 16'd7, 16'd100};
        tmo_set                = '{8'd0, 8'd255, 8'd1, 8'd5, 8'd20, 8'd100};
        errors                 = 0;
        stall_cycles           = 0;
        src_idle_pct           = 11;
        snk_idle_pct           = 45;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = REG_CHANNEL_COUNT;
        cfg_data               = '0;
        in_ch.valid            = 1'b0;
        in_ch.command          = CMD_SAMPLE;
        in_ch.channel          = '0;
        in_ch.voltage          = '0;
        in_ch.requested_frames = '0;
        out_ch.ready           = 1'b0;
        model_reset();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: two channels, single-frame default, three-tick timeout.
        write_regs(5'd2, 16'd1, 8'd3);

        add_typed(CMD_UNUSED, 0, 0, 0, 0, '0, '0);             // dropped
        add_typed(CMD_SAMPLE, 5, 0, 0, 0, '0, '0);             // channel past count
        add_typed(CMD_TICK, 0, 0, 0, 0, '0, '0);
        add_typed(CMD_TICK, 0, 0, 0, 0, '0, '0);
        // timeout in the start-up pass: reported, calibration restarts
        add_typed(CMD_TICK, 0, 0, 0, 1, mk_res(RK_FAIL, 0, 0, 1), '0);
        add_typed(CMD_START, 0, 0, 1, 0, '0, '0);
        add_typed(CMD_SAMPLE, 0, 16'sh8000, 0, 0, '0, '0);      // not published yet
        add_typed(CMD_SAMPLE, 1, 16'sh7FFF, 0, 1, mk_res(RK_OK, 0, 0, 1), '0);
        add_typed(CMD_SAMPLE, 0, 16'sh7FFF, 0, 1, mk_res(RK_SAMPLE, 0, 65535, 1), '0);
        add_typed(CMD_SAMPLE, 1, 16'sh8000, 0, 1, mk_res(RK_SAMPLE, 1, -65535, 1), '0);
        add_typed(CMD_TICK, 0, 0, 0, 0, '0, '0);               // idle tick
        add_typed(CMD_START, 0, 0, 0, 0, '0, '0);              // zero selects default
        add_typed(CMD_SAMPLE, 0, 0, 0, 1, mk_res(RK_SAMPLE, 0, 32768, 1), '0);
        add_typed(CMD_TICK, 0, 0, 0, 0, '0, '0);
        add_typed(CMD_TICK, 0, 0, 0, 0, '0, '0);
        // timeout after start-up: reported, calibration stops, bias kept
        add_typed(CMD_TICK, 0, 0, 0, 1, mk_res(RK_FAIL, 0, 0, 1), '0);
        add_row(CMD_START, 0, 0, 2);
        add_row(CMD_SAMPLE, 0, 100, 0);
        add_row(CMD_SAMPLE, 1, 200, 0);
        add_row(CMD_SAMPLE, 0, -100, 0);
        add_row(CMD_SAMPLE, 1, -201, 0);                        // sample, then success
        add_row(CMD_SAMPLE, 1, -5, 0);                          // -1/2 truncates to 0
        add_row(CMD_START, 0, 0, 16'hFFFF);
        add_row(CMD_START, 0, 0, 3);                            // restart mid-run

        foreach (rows[i]) begin
            r = rows[i];
            send_item(r.cmd, r.chan, r.volts, r.req, r.typed, r.n_res, r.r0, r.r1);
        end

        // Random part over six register settings and three idling modes.
        for (int ph = 0; ph < 6; ph++) begin
            quiesce();
            src_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 45 : 0;
            snk_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 11 : 0;
            write_regs(cnt_set[ph], dflt_set[ph], tmo_set[ph]);
            send(CMD_START, 0, 0, 16'($urandom_range(1, 3)));
            random_phase(315);
        end

        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (CFG_SETTLE) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

[sensor_offset_calibrate_remove.f]
rtl/socr_pkg.sv
rtl/socr_if.sv
rtl/socr_front.sv
rtl/socr_queue.sv
rtl/socr_back.sv
rtl/sensor_offset_calibrate_remove.sv
tb/tb_sensor_offset_calibrate_remove.sv
